### hdl/triangular_histogram_smoother_core_defines.svh
// assertion macros for the triangular histogram smoother
// used by the modules that assert; expects clk and rst_n in scope
`ifndef TRIANGULAR_HISTOGRAM_SMOOTHER_CORE_DEFINES_SVH
`define TRIANGULAR_HISTOGRAM_SMOOTHER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define THS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define THS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define THS_ASSERT(lbl, expr, msg)
`define THS_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

### hdl/thsm_pkg.sv
// shared types and constants of the triangular histogram smoother
// no dependencies
package thsm_pkg;

  localparam int MAX_HALF    = 63;
  localparam int COUNT_BITS  = 32;
  localparam int STORE_DEPTH = 2 * MAX_HALF + 1;
  localparam int HALF_W      = 6;
  localparam int RUN_W       = 7;
  localparam int SLOT_W      = 7;
  localparam int RUN_SAT     = 127;
  localparam int WEIGHT_W    = HALF_W + 1;
  localparam int PROD_W      = COUNT_BITS + WEIGHT_W;
  localparam int DEN_W       = 14;
  localparam int NUM_W       = COUNT_BITS + DEN_W;
  localparam int DIV_CNT_W   = $clog2(NUM_W);

  typedef struct packed {
    logic [31:0] bin_count;
    logic        last_bin;
  } in_item_t;

  typedef struct packed {
    logic [31:0] smoothed_count;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [RUN_W-1:0]      n;
    logic [HALF_W-1:0]     kmax;
    logic                  last;
    logic                  emit;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

endpackage

### hdl/triangular_histogram_smoother_core.sv
// Triangular histogram smoother. Bins enter one per push; each bin that
// completes a window produces one smoothed result, and the marked last bin
// flushes up to half_width+1 results, oldest first. A job is picked off
// the queue; each of its results then takes setup, left+right+1 taps (at
// most 2*half_width+1, up to 127) through the single store read port and
// multiplier, pipeline drain, the bit-serial divider and a load of the
// result register. A two-entry job queue lets bins be pushed while
// results are worked out or wait to be popped. half_width may only be
// written while idle.
// depends on thsm_pkg, thsm_front, thsm_job_queue, thsm_back
module triangular_histogram_smoother_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [5:0]          cfg_half_width,
  input  logic                in_push,
  input  thsm_pkg::in_item_t  in_data,
  output logic                in_full,
  input  logic                out_pop,
  output logic                out_empty,
  output thsm_pkg::out_item_t out_data
);

  logic [thsm_pkg::HALF_W-1:0] half_width_r;
  logic [thsm_pkg::HALF_W-1:0] half;
  logic                        q_full;
  logic                        q_push;
  thsm_pkg::job_t              q_in;
  logic                        q_empty;
  logic                        q_pop;
  thsm_pkg::job_t              q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= '0;
    end else if (cfg_wr_en) begin
      half_width_r <= cfg_half_width;
    end
  end

  assign half = (half_width_r > thsm_pkg::HALF_W'(thsm_pkg::MAX_HALF))
                ? thsm_pkg::HALF_W'(thsm_pkg::MAX_HALF) : half_width_r;

  thsm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .half    (half),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  thsm_job_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  thsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .half      (half),
    .job_empty (q_empty),
    .job       (q_out),
    .job_pop   (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

### hdl/thsm_front.sv
// front end: accepts bins, tracks the run length and classifies each bin
// into a job for the back end; uses thsm_pkg
module thsm_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [thsm_pkg::HALF_W-1:0] half,
  input  logic                       in_push,
  input  thsm_pkg::in_item_t         in_data,
  output logic                       in_full,
  input  logic                       q_full,
  output logic                       q_push,
  output thsm_pkg::job_t             q_data
);

  logic [thsm_pkg::RUN_W-1:0] rsf_r, rsf_nxt;
  logic [thsm_pkg::RUN_W-1:0] n_new;
  logic [thsm_pkg::RUN_W-1:0] n_m1;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  always_comb begin
    n_new = (rsf_r < thsm_pkg::RUN_W'(thsm_pkg::RUN_SAT)) ? rsf_r + 1'b1 : rsf_r;
    n_m1  = n_new - 1'b1;
    rsf_nxt = in_data.last_bin ? '0 : n_new;
    q_data.count = in_data.bin_count[thsm_pkg::COUNT_BITS-1:0];
    q_data.n     = n_new;
    q_data.last  = in_data.last_bin;
    // end of run flushes min(n-1, h) down to zero
    if (in_data.last_bin && (n_m1 < {1'b0, half})) begin
      q_data.kmax = n_m1[thsm_pkg::HALF_W-1:0];
    end else begin
      q_data.kmax = half;
    end
    q_data.emit = in_data.last_bin || (n_new > {1'b0, half});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsf_r <= '0;
    end else if (q_push) begin
      rsf_r <= rsf_nxt;
    end
  end

endmodule

### hdl/thsm_job_queue.sv
// two-entry queue of jobs between front and back end
// uses thsm_pkg
module thsm_job_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  thsm_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output thsm_pkg::job_t pop_data
);

  thsm_pkg::job_t slots [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### hdl/thsm_div.sv
// restoring divider, one quotient bit per cycle
// uses thsm_pkg
module thsm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  thsm_pkg::div_req_t req,
  output thsm_pkg::div_rsp_t rsp
);

  logic                           busy_r;
  logic                           done_r;
  logic [thsm_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [thsm_pkg::NUM_W-1:0]     quot_r;
  logic [thsm_pkg::DEN_W-1:0]     rem_r;
  logic [thsm_pkg::DEN_W-1:0]     den_r;
  logic [thsm_pkg::DEN_W:0]       rem_sh;
  logic                           take;
  logic [thsm_pkg::DEN_W-1:0]     rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, quot_r[thsm_pkg::NUM_W-1]};
    take    = (rem_sh >= {1'b0, den_r});
    rem_nxt = take ? thsm_pkg::DEN_W'(rem_sh - {1'b0, den_r})
                   : rem_sh[thsm_pkg::DEN_W-1:0];
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == thsm_pkg::DIV_CNT_W'(thsm_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r <= req.num;
      rem_r  <= '0;
      den_r  <= req.den;
    end else if (busy_r) begin
      quot_r <= {quot_r[thsm_pkg::NUM_W-2:0], take};
      rem_r  <= rem_nxt;
    end
  end

endmodule

### hdl/thsm_back.sv
// back end: bin store, tap sequencer, multiply-accumulate, rounding and
// the result register; uses thsm_pkg and thsm_div
`include "triangular_histogram_smoother_core_defines.svh"

module thsm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [thsm_pkg::HALF_W-1:0] half,
  input  logic                        job_empty,
  input  thsm_pkg::job_t              job,
  output logic                        job_pop,
  input  logic                        out_pop,
  output logic                        out_empty,
  output thsm_pkg::out_item_t         out_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_RUN, ST_DRAIN, ST_DIV, ST_OUT
  } state_t;

  state_t state_r;

  logic [thsm_pkg::COUNT_BITS-1:0] store_mem [thsm_pkg::STORE_DEPTH];
  logic [thsm_pkg::SLOT_W-1:0]     wp_r;
  logic [thsm_pkg::SLOT_W-1:0]     newest_r;
  logic [thsm_pkg::RUN_W-1:0]      n_r;
  logic [thsm_pkg::HALF_W-1:0]     kmax_r;
  logic [thsm_pkg::HALF_W-1:0]     k_r;
  logic                            last_r;
  logic signed [7:0]               d_r;
  logic [thsm_pkg::NUM_W-1:0]      acc_r;
  logic [thsm_pkg::DEN_W-1:0]      den_r;
  logic                            out_valid_r;
  thsm_pkg::out_item_t             out_item_r;

  // tap pipeline: read, multiply, accumulate
  logic [thsm_pkg::COUNT_BITS-1:0] rd_data_r;
  logic [thsm_pkg::WEIGHT_W-1:0]   w_s1_r;
  logic                            v_s1_r;
  logic [thsm_pkg::PROD_W-1:0]     prod_r;
  logic                            v_s2_r;

  logic                            issue;
  logic [thsm_pkg::RUN_W-1:0]      left_raw;
  logic [thsm_pkg::HALF_W-1:0]     left;
  logic signed [7:0]               right;
  logic [7:0]                      absd;
  logic [thsm_pkg::WEIGHT_W-1:0]   weight;
  logic signed [7:0]               back_idx;
  logic signed [7:0]               diff;
  logic [thsm_pkg::SLOT_W-1:0]     rd_slot;
  logic [thsm_pkg::DEN_W:0]        rem2;
  logic                            round_up;
  thsm_pkg::div_req_t              div_req;
  thsm_pkg::div_rsp_t              div_rsp;

  thsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign job_pop   = (state_r == ST_IDLE) && !job_empty;
  assign issue     = (state_r == ST_RUN);
  assign out_empty = !out_valid_r;
  assign out_data  = out_item_r;

  always_comb begin
    left_raw = n_r - thsm_pkg::RUN_W'(1) - {1'b0, k_r};
    left     = (left_raw > {1'b0, half}) ? half : left_raw[thsm_pkg::HALF_W-1:0];
    right    = $signed({2'b00, k_r});
    absd     = d_r[7] ? 8'(-d_r) : 8'(d_r);
    weight   = {half - absd[thsm_pkg::HALF_W-1:0], 1'b1};
    back_idx = right - d_r;
    diff     = $signed({1'b0, newest_r}) - back_idx;
    // store is circular over an odd depth
    rd_slot  = diff[7] ? thsm_pkg::SLOT_W'(diff + 8'(thsm_pkg::STORE_DEPTH))
                       : diff[thsm_pkg::SLOT_W-1:0];
    rem2     = {div_rsp.rem, 1'b0};
    round_up = (rem2 > {1'b0, den_r}) || ((rem2 == {1'b0, den_r}) && div_rsp.quot[0]);
    div_req.start = (state_r == ST_DRAIN) && !v_s1_r && !v_s2_r;
    div_req.num   = acc_r;
    div_req.den   = den_r;
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      store_mem[wp_r] <= job.count;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= store_mem[rd_slot];
    w_s1_r    <= weight;
    prod_r    <= rd_data_r * w_s1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r <= 1'b0;
      v_s2_r <= 1'b0;
    end else begin
      v_s1_r <= issue;
      v_s2_r <= v_s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      if (v_s2_r) acc_r <= acc_r + thsm_pkg::NUM_W'(prod_r);
      unique case (state_r)
        ST_IDLE: begin
          if (!job_empty) begin
            newest_r <= wp_r;
            wp_r     <= (wp_r == thsm_pkg::SLOT_W'(thsm_pkg::STORE_DEPTH - 1))
                        ? '0 : wp_r + 1'b1;
            n_r      <= job.n;
            kmax_r   <= job.kmax;
            k_r      <= job.kmax;
            last_r   <= job.last;
            if (job.emit) state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          d_r     <= -$signed({2'b00, left});
          acc_r   <= '0;
          den_r   <= '0;
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          den_r <= den_r + thsm_pkg::DEN_W'(weight);
          if (d_r == right) begin
            state_r <= ST_DRAIN;
          end else begin
            d_r <= d_r + 8'sd1;
          end
        end
        ST_DRAIN: begin
          if (!v_s1_r && !v_s2_r) state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) state_r <= ST_OUT;
        end
        ST_OUT: begin
          // quotient and remainder hold in the divider until its next start
          if (!out_valid_r) begin
            out_item_r.smoothed_count <= div_rsp.quot[thsm_pkg::COUNT_BITS-1:0]
                                         + thsm_pkg::COUNT_BITS'(round_up);
            out_item_r.last_result    <= last_r && (k_r == '0);
            out_valid_r <= 1'b1;
            if (last_r && (k_r != '0)) begin
              k_r     <= k_r - 1'b1;
              state_r <= ST_SETUP;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `THS_ASSERT_IMPL(a_idle_no_taps, state_r == ST_IDLE, !v_s1_r && !v_s2_r, "taps busy in idle")
  `THS_ASSERT_IMPL(a_div_den_nonzero, state_r == ST_DIV, den_r != '0, "zero weight sum at division")
  `THS_ASSERT_IMPL(a_k_in_range, state_r != ST_IDLE, k_r <= kmax_r, "bin offset beyond job range")
  `THS_ASSERT_IMPL(a_done_in_div, div_rsp.done, state_r == ST_DIV, "divider done outside division")

endmodule
